[src/rfsc_pkg.sv]
`default_nettype none

package rfsc_pkg;

    // Default frame length limits.
    localparam int RFSC_MAX_FRAME_LEN = 127;
    localparam int RFSC_MIN_FRAME_LEN = 3;

    // Request codes
    localparam logic [3:0] REQ_ON       = 4'd0;
    localparam logic [3:0] REQ_OFF      = 4'd1;
    localparam logic [3:0] REQ_RESET    = 4'd2;
    localparam logic [3:0] REQ_TRANSMIT = 4'd3;
    localparam logic [3:0] REQ_RECEIVE  = 4'd4;
    localparam logic [3:0] REQ_IRQ      = 4'd5;
    localparam logic [3:0] REQ_TX_LOAD  = 4'd6;
    localparam logic [3:0] REQ_TX_BYTE  = 4'd7;
    localparam logic [3:0] REQ_RX_BYTE  = 4'd8;

    // Radio mode codes
    localparam logic [2:0] MODE_OFF      = 3'd0;
    localparam logic [2:0] MODE_IDLE     = 3'd1;
    localparam logic [2:0] MODE_RX_INIT  = 3'd2;
    localparam logic [2:0] MODE_RX_BUSY  = 3'd3;
    localparam logic [2:0] MODE_RX_DONE  = 3'd4;
    localparam logic [2:0] MODE_TX_INIT  = 3'd5;
    localparam logic [2:0] MODE_TX_BUSY  = 3'd6;
    localparam logic [2:0] MODE_TX_DONE  = 3'd7;

    // Receive deframer phases
    localparam logic [1:0] RXP_LENGTH  = 2'd0;
    localparam logic [1:0] RXP_PAYLOAD = 2'd1;
    localparam logic [1:0] RXP_RSSI    = 2'd2;
    localparam logic [1:0] RXP_STATUS  = 2'd3;

    // Status codes
    localparam logic [1:0] ST_SUCCESS  = 2'd0;
    localparam logic [1:0] ST_ERROR    = 2'd1;
    localparam logic [1:0] ST_PENDING  = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] CFG_RX_START_EN = 3'd0;
    localparam logic [2:0] CFG_RX_DONE_EN  = 3'd1;
    localparam logic [2:0] CFG_TX_START_EN = 3'd2;
    localparam logic [2:0] CFG_TX_DONE_EN  = 3'd3;
    localparam logic [2:0] CFG_RX_CAPACITY = 3'd4;
    localparam logic [2:0] CFG_RSSI_OFFSET = 3'd5;

    localparam logic [6:0] RX_CAPACITY_RST = 7'd125;
    localparam logic [6:0] RSSI_OFFSET_RST = 7'd73;

    // Notify bits
    localparam logic [3:0] NTF_RX_START = 4'b0001;
    localparam logic [3:0] NTF_RX_DONE  = 4'b0010;
    localparam logic [3:0] NTF_TX_START = 4'b0100;
    localparam logic [3:0] NTF_TX_DONE  = 4'b1000;

    typedef struct packed {
        logic [1:0] status;
        logic [2:0] radio_mode;
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       last;
        logic [6:0] frame_length;
        logic [7:0] rssi;
        logic       crc_ok;
        logic [6:0] lqi;
        logic       flush_rx;
        logic       flush_tx;
        logic [3:0] notify;
    } t_result;

endpackage

`default_nettype wire

[src/radio_frame_state_controller_unit.sv]
`default_nettype none

// Radio frame state controller.
// Input channel: one transaction carries a request (command, interrupt event
// set, transmit load/byte or received FIFO byte) on i_in_valid / o_in_stall.
// Output channel: exactly one result transaction per input transaction on
// o_out_valid / i_out_stall, in order.
// The result of an accepted transaction is registered in the result register,
// or in the skid register while the result register is held. Throughput is one
// transaction per cycle while o_in_stall is low; the whole update is a single pass
// of logic from the mode and deframer registers to the result register.
// When the receiver stalls, the result register holds and one more result is
// taken into a skid register; o_in_stall rises only once the skid register
// is full, and it comes straight from a flop.
// Configuration is written through i_cfg_we / i_cfg_index / i_cfg_data; the user
// must do so only while no transaction is outstanding, the block does not enforce it.
// Synchronous reset (i_rst_n low) sets the mode to off, clears the deframer
// and the transmit count, empties both output stages and loads the
// configuration registers with their reset values.
module radio_frame_state_controller_unit
    import rfsc_pkg::*;
#(
    parameter int MAX_FRAME_LEN = RFSC_MAX_FRAME_LEN,
    parameter int MIN_FRAME_LEN = RFSC_MIN_FRAME_LEN
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,

    input  wire logic              i_cfg_we,
    input  wire logic [2:0]        i_cfg_index,
    input  wire logic [6:0]        i_cfg_data,

    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic [3:0]        i_req_type,
    input  wire logic [7:0]        i_data_byte,
    input  wire logic              i_irq_sfd,
    input  wire logic              i_irq_rx_done,
    input  wire logic              i_irq_tx_done,

    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic [1:0]             o_status,
    output logic [2:0]             o_radio_mode,
    output logic [7:0]             o_out_byte,
    output logic                   o_byte_valid,
    output logic                   o_last,
    output logic [6:0]             o_frame_length,
    output logic signed [7:0]      o_rssi,
    output logic                   o_crc_ok,
    output logic [6:0]             o_lqi,
    output logic                   o_flush_rx,
    output logic                   o_flush_tx,
    output logic [3:0]             o_notify
);

    // The transmit count holds at most MAX_FRAME_LEN - 2.
    localparam int TX_CNT_W = (MAX_FRAME_LEN > 3) ? $clog2(MAX_FRAME_LEN - 1) : 1;
    localparam logic [8:0] MAX_LEN9 = 9'(MAX_FRAME_LEN);
    localparam logic [8:0] MIN_LEN9 = 9'(MIN_FRAME_LEN);

    // Configuration registers
    logic       r_rx_start_en;
    logic       r_rx_done_en;
    logic       r_tx_start_en;
    logic       r_tx_done_en;
    logic [6:0] r_rx_capacity;
    logic [6:0] r_rssi_offset;

    // Controller state
    logic [2:0]          r_mode,        n_mode;
    logic [1:0]          r_rx_phase,    n_rx_phase;
    logic [6:0]          r_rx_remain,   n_rx_remain;
    logic [6:0]          r_rx_len,      n_rx_len;
    logic [7:0]          r_rssi_hold,   n_rssi_hold;
    logic [TX_CNT_W-1:0] r_tx_remain,   n_tx_remain;

    // Output register and skid register
    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    t_result n_res;

    logic       accept_in;
    logic       take_out;
    logic [8:0] tx_plen;
    logic [8:0] rx_plen;
    logic [2:0] irq_mode_a;
    logic [2:0] irq_mode_b;
    logic [3:0] irq_notify;

    assign accept_in = i_in_valid && !r_skid_valid;
    assign take_out  = r_out_valid && !i_out_stall;

    assign tx_plen = {1'b0, i_data_byte} + 9'd2;
    assign rx_plen = {1'b0, i_data_byte} - 9'd2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_start_en <= 1'b0;
            r_rx_done_en  <= 1'b0;
            r_tx_start_en <= 1'b0;
            r_tx_done_en  <= 1'b0;
            r_rx_capacity <= RX_CAPACITY_RST;
            r_rssi_offset <= RSSI_OFFSET_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_RX_START_EN: r_rx_start_en <= i_cfg_data[0];
                CFG_RX_DONE_EN:  r_rx_done_en  <= i_cfg_data[0];
                CFG_TX_START_EN: r_tx_start_en <= i_cfg_data[0];
                CFG_TX_DONE_EN:  r_tx_done_en  <= i_cfg_data[0];
                CFG_RX_CAPACITY: r_rx_capacity <= i_cfg_data;
                CFG_RSSI_OFFSET: r_rssi_offset <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Interrupt events apply in order: start of frame, receive done, transmit
    // done, each one seeing the mode left by the one before.
    always_comb begin
        irq_mode_a = r_mode;
        irq_notify = '0;
        if (i_irq_sfd) begin
            if (r_mode == MODE_RX_INIT && r_rx_start_en) begin
                irq_mode_a = MODE_RX_BUSY;
                irq_notify = irq_notify | NTF_RX_START;
            end else if (r_mode == MODE_TX_INIT && r_tx_start_en) begin
                irq_mode_a = MODE_TX_BUSY;
                irq_notify = irq_notify | NTF_TX_START;
            end
        end
        irq_mode_b = irq_mode_a;
        if (i_irq_rx_done && irq_mode_a == MODE_RX_BUSY && r_rx_done_en) begin
            irq_mode_b = MODE_RX_DONE;
            irq_notify = irq_notify | NTF_RX_DONE;
        end
        if (i_irq_tx_done && irq_mode_b == MODE_TX_BUSY && r_tx_done_en) begin
            irq_mode_b = MODE_TX_DONE;
            irq_notify = irq_notify | NTF_TX_DONE;
        end
    end

    always_comb begin
        n_mode      = r_mode;
        n_rx_phase  = r_rx_phase;
        n_rx_remain = r_rx_remain;
        n_rx_len    = r_rx_len;
        n_rssi_hold = r_rssi_hold;
        n_tx_remain = r_tx_remain;
        n_res       = '0;
        n_res.status = ST_SUCCESS;

        unique case (i_req_type)
            REQ_ON: begin
                n_mode = MODE_IDLE;
            end
            REQ_OFF: begin
                n_mode     = MODE_OFF;
                n_rx_phase = RXP_LENGTH;
            end
            REQ_RESET: begin
                n_mode         = MODE_OFF;
                n_rx_phase     = RXP_LENGTH;
                n_tx_remain    = '0;
                n_res.flush_rx = 1'b1;
                n_res.flush_tx = 1'b1;
            end
            REQ_TRANSMIT: begin
                n_mode = MODE_TX_INIT;
            end
            REQ_RECEIVE: begin
                n_res.flush_rx = 1'b1;
                n_rx_phase     = RXP_LENGTH;
                n_mode         = MODE_RX_INIT;
            end
            REQ_IRQ: begin
                n_mode       = irq_mode_b;
                n_res.notify = irq_notify;
            end
            REQ_TX_LOAD: begin
                if (r_mode != MODE_IDLE || tx_plen > MAX_LEN9 || tx_plen <= MIN_LEN9) begin
                    n_res.status = ST_ERROR;
                end else begin
                    n_res.flush_tx   = 1'b1;
                    n_res.out_byte   = tx_plen[7:0];
                    n_res.byte_valid = 1'b1;
                    n_tx_remain      = i_data_byte[TX_CNT_W-1:0];
                    if (i_data_byte == 8'd0) begin
                        n_res.last = 1'b1;
                    end else begin
                        n_res.status = ST_PENDING;
                    end
                end
            end
            REQ_TX_BYTE: begin
                if (r_tx_remain == '0) begin
                    n_res.status = ST_ERROR;
                end else begin
                    n_res.out_byte   = i_data_byte;
                    n_res.byte_valid = 1'b1;
                    n_tx_remain      = r_tx_remain - TX_CNT_W'(1);
                    if (r_tx_remain == TX_CNT_W'(1)) begin
                        n_res.last = 1'b1;
                    end else begin
                        n_res.status = ST_PENDING;
                    end
                end
            end
            REQ_RX_BYTE: begin
                if (r_mode != MODE_RX_DONE) begin
                    n_res.status = ST_ERROR;
                end else begin
                    case (r_rx_phase)
                        RXP_LENGTH: begin
                            if ({1'b0, i_data_byte} > MAX_LEN9 ||
                                {1'b0, i_data_byte} <= MIN_LEN9 ||
                                i_data_byte < 8'd2 ||
                                rx_plen > {2'b00, r_rx_capacity}) begin
                                n_res.flush_rx = 1'b1;
                                n_res.status   = ST_ERROR;
                            end else begin
                                n_rx_len     = rx_plen[6:0];
                                n_rx_remain  = rx_plen[6:0];
                                n_rx_phase   = (rx_plen[6:0] != 7'd0) ? RXP_PAYLOAD
                                                                       : RXP_RSSI;
                                n_res.status = ST_PENDING;
                            end
                        end
                        RXP_PAYLOAD: begin
                            n_res.out_byte   = i_data_byte;
                            n_res.byte_valid = 1'b1;
                            // The phase ends when the count reaches zero.
                            if (r_rx_remain <= 7'd1) begin
                                n_rx_remain = 7'd0;
                                n_rx_phase  = RXP_RSSI;
                            end else begin
                                n_rx_remain = r_rx_remain - 7'd1;
                            end
                            n_res.status = ST_PENDING;
                        end
                        RXP_RSSI: begin
                            n_rssi_hold  = i_data_byte - {1'b0, r_rssi_offset};
                            n_rx_phase   = RXP_STATUS;
                            n_res.status = ST_PENDING;
                        end
                        default: begin
                            n_res.last         = 1'b1;
                            n_res.frame_length = r_rx_len;
                            n_res.rssi         = r_rssi_hold;
                            n_res.crc_ok       = i_data_byte[7];
                            n_res.lqi          = i_data_byte[6:0];
                            n_res.flush_rx     = 1'b1;
                            n_mode             = MODE_IDLE;
                            n_rx_phase         = RXP_LENGTH;
                        end
                    endcase
                end
            end
            default: begin
                n_res.status = ST_ERROR;
            end
        endcase

        n_res.radio_mode = n_mode;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_OFF;
            r_rx_phase  <= RXP_LENGTH;
            r_rx_remain <= '0;
            r_rx_len    <= '0;
            r_rssi_hold <= '0;
            r_tx_remain <= '0;
        end else if (accept_in) begin
            r_mode      <= n_mode;
            r_rx_phase  <= n_rx_phase;
            r_rx_remain <= n_rx_remain;
            r_rx_len    <= n_rx_len;
            r_rssi_hold <= n_rssi_hold;
            r_tx_remain <= n_tx_remain;
        end
    end

    // The skid register only fills while the output register is held by a
    // stall, so it always drains into the output register first.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (take_out || !r_out_valid) begin
            r_out_valid  <= r_skid_valid || accept_in;
            r_skid_valid <= 1'b0;
        end else if (accept_in) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_out || !r_out_valid) begin
            r_out <= r_skid_valid ? r_skid : n_res;
        end
        if (accept_in) begin
            r_skid <= n_res;
        end
    end

    assign o_in_stall     = r_skid_valid;
    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out.status;
    assign o_radio_mode   = r_out.radio_mode;
    assign o_out_byte     = r_out.out_byte;
    assign o_byte_valid   = r_out.byte_valid;
    assign o_last         = r_out.last;
    assign o_frame_length = r_out.frame_length;
    assign o_rssi         = r_out.rssi;
    assign o_crc_ok       = r_out.crc_ok;
    assign o_lqi          = r_out.lqi;
    assign o_flush_rx     = r_out.flush_rx;
    assign o_flush_tx     = r_out.flush_tx;
    assign o_notify       = r_out.notify;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register full while output register empty");

    a_skid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && i_out_stall) |=> (r_skid_valid && $stable(r_skid)))
        else $error("skid result lost during stall");

    a_byte_not_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_byte_valid) |-> (o_status != ST_ERROR))
        else $error("byte emitted on an error result");

    a_notify_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_notify != 4'd0) |->
            (o_radio_mode == MODE_RX_BUSY || o_radio_mode == MODE_RX_DONE ||
             o_radio_mode == MODE_TX_BUSY || o_radio_mode == MODE_TX_DONE))
        else $error("handler fired without a receive or transmit phase");

    // A result taken while the output register is held lands in the skid
    // register, so the check looks there first.
    a_rx_phase_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept_in && i_req_type == REQ_RX_BYTE && r_rx_phase != RXP_LENGTH &&
         r_mode == MODE_RX_DONE) |=>
            (r_out_valid && (r_skid_valid ? r_skid.status : r_out.status) != ST_ERROR))
        else $error("deframer byte answered with an error");

endmodule

`default_nettype wire

[bench/tb_radio_frame_state_controller_unit.sv]
`default_nettype none

module tb_radio_frame_state_controller_unit;
    import rfsc_pkg::*;

    localparam int QUIET_LIMIT       = 4000;
    localparam int ITEMS_PER_SECTION = 221;
    localparam int LONG_HOLD_CYCLES  = 80;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_we = 1'b0;
    logic [2:0] i_cfg_index = '0;
    logic [6:0] i_cfg_data = '0;
    logic       i_in_valid = 1'b0;
    logic       o_in_stall;
    logic [3:0] i_req_type = '0;
    logic [7:0] i_data_byte = '0;
    logic       i_irq_sfd = 1'b0;
    logic       i_irq_rx_done = 1'b0;
    logic       i_irq_tx_done = 1'b0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    logic [1:0] o_status;
    logic [2:0] o_radio_mode;
    logic [7:0] o_out_byte;
    logic       o_byte_valid;
    logic       o_last;
    logic [6:0] o_frame_length;
    logic [7:0] o_rssi;
    logic       o_crc_ok;
    logic [6:0] o_lqi;
    logic       o_flush_rx;
    logic       o_flush_tx;
    logic [3:0] o_notify;

    int unsigned sender_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned items_sent = 0;
    int unsigned quiet_cycles = 0;
    int          hold_left = 0;
    bit          hold_req = 1'b0;

    class radio_result_board;
        t_result     radio_results_due[$];
        int unsigned errors;

        logic       rx_start_en, rx_done_en, tx_start_en, tx_done_en;
        logic [6:0] rx_capacity, rssi_offset;

        logic [2:0] mode;
        logic [1:0] rx_phase;
        logic [6:0] rx_remaining, rx_length_hold, tx_remaining;
        logic [7:0] rssi_hold;

        function new();
            errors = 0;
            rx_start_en = 1'b0;
            rx_done_en = 1'b0;
            tx_start_en = 1'b0;
            tx_done_en = 1'b0;
            rx_capacity = RX_CAPACITY_RST;
            rssi_offset = RSSI_OFFSET_RST;
            mode = MODE_OFF;
            rx_phase = RXP_LENGTH;
            rx_remaining = '0;
            rx_length_hold = '0;
            tx_remaining = '0;
            rssi_hold = '0;
        endfunction

        function void write_reg(logic [2:0] index, logic [6:0] value);
            case (index)
                CFG_RX_START_EN: rx_start_en = value[0];
                CFG_RX_DONE_EN:  rx_done_en = value[0];
                CFG_TX_START_EN: tx_start_en = value[0];
                CFG_TX_DONE_EN:  tx_done_en = value[0];
                CFG_RX_CAPACITY: rx_capacity = value;
                CFG_RSSI_OFFSET: rssi_offset = value;
                default: ;
            endcase
        endfunction

        function t_result next_radio_result(logic [3:0] req, logic [7:0] db,
                                            logic sfd, logic rxd, logic txd);
            t_result     r;
            int unsigned phy_len;
            r = '0;
            r.status = ST_SUCCESS;
            case (req)
                REQ_ON: mode = MODE_IDLE;
                REQ_OFF: begin
                    mode = MODE_OFF;
                    rx_phase = RXP_LENGTH;
                end
                REQ_RESET: begin
                    mode = MODE_OFF;
                    rx_phase = RXP_LENGTH;
                    tx_remaining = '0;
                    r.flush_rx = 1'b1;
                    r.flush_tx = 1'b1;
                end
                REQ_TRANSMIT: mode = MODE_TX_INIT;
                REQ_RECEIVE: begin
                    r.flush_rx = 1'b1;
                    rx_phase = RXP_LENGTH;
                    mode = MODE_RX_INIT;
                end
                REQ_IRQ: begin
                    // Each event acts on the mode left by the one before it.
                    if (sfd) begin
                        if (mode == MODE_RX_INIT && rx_start_en) begin
                            mode = MODE_RX_BUSY;
                            r.notify |= NTF_RX_START;
                        end else if (mode == MODE_TX_INIT && tx_start_en) begin
                            mode = MODE_TX_BUSY;
                            r.notify |= NTF_TX_START;
                        end
                    end
                    if (rxd && mode == MODE_RX_BUSY && rx_done_en) begin
                        mode = MODE_RX_DONE;
                        r.notify |= NTF_RX_DONE;
                    end
                    if (txd && mode == MODE_TX_BUSY && tx_done_en) begin
                        mode = MODE_TX_DONE;
                        r.notify |= NTF_TX_DONE;
                    end
                end
                REQ_TX_LOAD: begin
                    phy_len = int'(db) + 2;
                    if (mode != MODE_IDLE || phy_len > RFSC_MAX_FRAME_LEN ||
                        phy_len <= RFSC_MIN_FRAME_LEN) begin
                        r.status = ST_ERROR;
                    end else begin
                        r.flush_tx = 1'b1;
                        r.out_byte = phy_len[7:0];
                        r.byte_valid = 1'b1;
                        tx_remaining = db[6:0];
                        if (db == 8'd0) r.last = 1'b1;
                        else r.status = ST_PENDING;
                    end
                end
                REQ_TX_BYTE: begin
                    if (tx_remaining == 7'd0) begin
                        r.status = ST_ERROR;
                    end else begin
                        r.out_byte = db;
                        r.byte_valid = 1'b1;
                        tx_remaining = tx_remaining - 7'd1;
                        if (tx_remaining == 7'd0) r.last = 1'b1;
                        else r.status = ST_PENDING;
                    end
                end
                REQ_RX_BYTE: begin
                    if (mode != MODE_RX_DONE) begin
                        r.status = ST_ERROR;
                    end else begin
                        case (rx_phase)
                            RXP_LENGTH: begin
                                if (db > RFSC_MAX_FRAME_LEN || db <= RFSC_MIN_FRAME_LEN ||
                                    db < 2 || int'(db) - 2 > int'(rx_capacity)) begin
                                    r.flush_rx = 1'b1;
                                    r.status = ST_ERROR;
                                end else begin
                                    rx_length_hold = 7'(db - 8'd2);
                                    rx_remaining = rx_length_hold;
                                    rx_phase = (rx_remaining != 0) ? RXP_PAYLOAD : RXP_RSSI;
                                    r.status = ST_PENDING;
                                end
                            end
                            RXP_PAYLOAD: begin
                                r.out_byte = db;
                                r.byte_valid = 1'b1;
                                if (rx_remaining != 0) rx_remaining = rx_remaining - 7'd1;
                                if (rx_remaining == 0) rx_phase = RXP_RSSI;
                                r.status = ST_PENDING;
                            end
                            RXP_RSSI: begin
                                rssi_hold = db - {1'b0, rssi_offset};
                                rx_phase = RXP_STATUS;
                                r.status = ST_PENDING;
                            end
                            default: begin
                                r.last = 1'b1;
                                r.frame_length = rx_length_hold;
                                r.rssi = rssi_hold;
                                r.crc_ok = db[7];
                                r.lqi = db[6:0];
                                r.flush_rx = 1'b1;
                                mode = MODE_IDLE;
                                rx_phase = RXP_LENGTH;
                            end
                        endcase
                    end
                end
                default: r.status = ST_ERROR;
            endcase
            r.radio_mode = mode;
            return r;
        endfunction

        function void note_request(logic [3:0] req, logic [7:0] db,
                                   logic sfd, logic rxd, logic txd);
            radio_results_due.push_back(next_radio_result(req, db, sfd, rxd, txd));
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (radio_results_due.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                errors++;
                return;
            end
            want = radio_results_due.pop_front();
            compare_field("status", want.status, got.status);
            compare_field("radio_mode", want.radio_mode, got.radio_mode);
            compare_field("out_byte", want.out_byte, got.out_byte);
            compare_field("byte_valid", want.byte_valid, got.byte_valid);
            compare_field("last", want.last, got.last);
            compare_field("frame_length", want.frame_length, got.frame_length);
            compare_field("rssi", want.rssi, got.rssi);
            compare_field("crc_ok", want.crc_ok, got.crc_ok);
            compare_field("lqi", want.lqi, got.lqi);
            compare_field("flush_rx", want.flush_rx, got.flush_rx);
            compare_field("flush_tx", want.flush_tx, got.flush_tx);
            compare_field("notify", want.notify, got.notify);
        endfunction

        function int unsigned outstanding();
            return radio_results_due.size();
        endfunction
    endclass

    radio_result_board board = new();

    radio_frame_state_controller_unit i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_req_type     (i_req_type),
        .i_data_byte    (i_data_byte),
        .i_irq_sfd      (i_irq_sfd),
        .i_irq_rx_done  (i_irq_rx_done),
        .i_irq_tx_done  (i_irq_tx_done),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_radio_mode   (o_radio_mode),
        .o_out_byte     (o_out_byte),
        .o_byte_valid   (o_byte_valid),
        .o_last         (o_last),
        .o_frame_length (o_frame_length),
        .o_rssi         (o_rssi),
        .o_crc_ok       (o_crc_ok),
        .o_lqi          (o_lqi),
        .o_flush_rx     (o_flush_rx),
        .o_flush_tx     (o_flush_tx),
        .o_notify       (o_notify)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // The long hold-off is counted here so the sender keeps offering meanwhile.
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            i_out_stall = 1'b1;
            hold_left--;
        end else if (hold_req) begin
            hold_req = 1'b0;
            hold_left = LONG_HOLD_CYCLES - 1;
            i_out_stall = 1'b1;
        end else begin
            i_out_stall = ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin : monitor
        t_result got;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                got = {o_status, o_radio_mode, o_out_byte, o_byte_valid, o_last,
                       o_frame_length, o_rssi, o_crc_ok, o_lqi, o_flush_rx,
                       o_flush_tx, o_notify};
                board.check_result(got);
            end
            if (i_in_valid && !o_in_stall) begin
                board.note_request(i_req_type, i_data_byte, i_irq_sfd,
                                   i_irq_rx_done, i_irq_tx_done);
            end
            if ((o_out_valid && !i_out_stall) || (i_in_valid && !o_in_stall)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= QUIET_LIMIT) begin
                    $display("end of test: mismatches");
                    $finish;
                end
            end
        end
    end

    task automatic send_req(input logic [3:0] req, input logic [7:0] db,
                            input logic sfd, input logic rxd, input logic txd);
        @(negedge i_clk);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_req_type = req;
        i_data_byte = db;
        i_irq_sfd = sfd;
        i_irq_rx_done = rxd;
        i_irq_tx_done = txd;
        do @(posedge i_clk); while (o_in_stall);
        items_sent++;
    endtask

    task automatic send_cmd(input logic [3:0] req);
        send_req(req, 8'($urandom_range(255)), 1'($urandom_range(1)),
                 1'($urandom_range(1)), 1'($urandom_range(1)));
    endtask

    task automatic write_cfg(input logic [2:0] index, input logic [6:0] value);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_index = index;
        i_cfg_data = value;
        board.write_reg(index, value);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic configure(input logic [3:0] enables, input logic [6:0] capacity,
                             input logic [6:0] offset);
        write_cfg(CFG_RX_START_EN, {6'd0, enables[0]});
        write_cfg(CFG_RX_DONE_EN, {6'd0, enables[1]});
        write_cfg(CFG_TX_START_EN, {6'd0, enables[2]});
        write_cfg(CFG_TX_DONE_EN, {6'd0, enables[3]});
        write_cfg(CFG_RX_CAPACITY, capacity);
        write_cfg(CFG_RSSI_OFFSET, offset);
    endtask

    // Stops offering requests and waits until the board expects no more results.
    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (board.outstanding() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic rx_frame_traffic();
        int unsigned cap;
        int unsigned pay;
        int unsigned tail;
        logic [7:0]  len_byte;
        cap = board.rx_capacity;
        if (cap < 2) pay = 2;
        else if ($urandom_range(19) == 0) pay = $urandom_range(cap, 2);
        else pay = $urandom_range((cap < 8) ? cap : 8, 2);
        len_byte = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : 8'(pay + 2);
        tail = pay + 2;
        if ($urandom_range(9) == 0) tail = $urandom_range(tail);
        send_cmd(REQ_RECEIVE);
        if ($urandom_range(1)) begin
            send_req(REQ_IRQ, 8'($urandom_range(255)), 1'b1, 1'b1, 1'($urandom_range(1)));
        end else begin
            send_req(REQ_IRQ, 8'($urandom_range(255)), 1'b1, 1'b0, 1'($urandom_range(1)));
            send_req(REQ_IRQ, 8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1,
                     1'($urandom_range(1)));
        end
        send_req(REQ_RX_BYTE, len_byte, 1'($urandom_range(1)), 1'($urandom_range(1)),
                 1'($urandom_range(1)));
        repeat (tail) send_cmd(REQ_RX_BYTE);
    endtask

    task automatic tx_frame_traffic();
        int unsigned pay;
        int unsigned count;
        if ($urandom_range(9) == 0) pay = $urandom_range(255);
        else if ($urandom_range(24) == 0) pay = $urandom_range(125, 2);
        else pay = $urandom_range(8, 2);
        count = (pay >= 2 && pay <= 125) ? pay : 1;
        if ($urandom_range(9) == 0) count = $urandom_range(count + 1);
        send_cmd(REQ_ON);
        send_req(REQ_TX_LOAD, 8'(pay), 1'($urandom_range(1)), 1'($urandom_range(1)),
                 1'($urandom_range(1)));
        repeat (count) send_cmd(REQ_TX_BYTE);
    endtask

    task automatic random_traffic(input int unsigned count);
        int unsigned stop_at;
        int unsigned kind;
        stop_at = items_sent + count;
        while (items_sent < stop_at) begin
            kind = $urandom_range(99);
            if (kind < 40) begin
                rx_frame_traffic();
            end else if (kind < 70) begin
                tx_frame_traffic();
            end else if (kind < 80) begin
                send_cmd(REQ_TRANSMIT);
                send_req(REQ_IRQ, 8'($urandom_range(255)), 1'b1, 1'($urandom_range(1)),
                         1'($urandom_range(1)));
                send_req(REQ_IRQ, 8'($urandom_range(255)), 1'($urandom_range(1)),
                         1'($urandom_range(1)), 1'b1);
            end else begin
                repeat ($urandom_range(4, 1)) send_cmd(4'($urandom_range(15)));
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        configure(4'b1111, 7'd125, 7'd73);

        // Unknown requests and requests that are illegal in the off mode, then the on request.
        send_req(4'd15, 8'hFF, 1'b1, 1'b1, 1'b1);
        send_req(4'd9, 8'h00, 1'b0, 1'b0, 1'b0);
        send_req(REQ_TX_LOAD, 8'd2, 1'b0, 1'b0, 1'b0);
        send_req(REQ_RX_BYTE, 8'd4, 1'b0, 1'b0, 1'b0);
        send_req(REQ_ON, 8'h00, 1'b0, 1'b0, 1'b0);
        // Transmit lengths on both sides of the frame limits.
        send_req(REQ_TX_LOAD, 8'd0, 1'b0, 1'b0, 1'b0);
        send_req(REQ_TX_LOAD, 8'd1, 1'b0, 1'b0, 1'b0);
        send_req(REQ_TX_LOAD, 8'd126, 1'b0, 1'b0, 1'b0);
        send_req(REQ_TX_LOAD, 8'd255, 1'b0, 1'b0, 1'b0);
        send_req(REQ_TX_LOAD, 8'd2, 1'b0, 1'b0, 1'b0);
        send_req(REQ_TX_BYTE, 8'h00, 1'b0, 1'b0, 1'b0);
        send_req(REQ_TX_BYTE, 8'hFF, 1'b0, 1'b0, 1'b0);
        send_req(REQ_TX_BYTE, 8'h5A, 1'b0, 1'b0, 1'b0);
        send_req(REQ_TX_LOAD, 8'd125, 1'b0, 1'b0, 1'b0);
        send_req(REQ_RESET, 8'h00, 1'b0, 1'b0, 1'b0);
        send_req(REQ_TX_BYTE, 8'hA5, 1'b0, 1'b0, 1'b0);
        // All three events in one transaction walk the transmit side.
        send_req(REQ_TRANSMIT, 8'h00, 1'b0, 1'b0, 1'b0);
        send_req(REQ_IRQ, 8'h00, 1'b1, 1'b1, 1'b1);
        send_req(REQ_RECEIVE, 8'h00, 1'b0, 1'b0, 1'b0);
        send_req(REQ_IRQ, 8'h00, 1'b1, 1'b1, 1'b0);
        send_req(REQ_RX_BYTE, 8'd128, 1'b0, 1'b0, 1'b0);
        send_req(REQ_RX_BYTE, 8'd3, 1'b0, 1'b0, 1'b0);
        send_req(REQ_RX_BYTE, 8'd4, 1'b0, 1'b0, 1'b0);
        send_req(REQ_RX_BYTE, 8'hAA, 1'b0, 1'b0, 1'b0);
        send_req(REQ_RX_BYTE, 8'h55, 1'b0, 1'b0, 1'b0);
        send_req(REQ_RX_BYTE, 8'h00, 1'b0, 1'b0, 1'b0);
        send_req(REQ_RX_BYTE, 8'hFF, 1'b0, 1'b0, 1'b0);
        send_req(REQ_OFF, 8'h00, 1'b0, 1'b0, 1'b0);
        drain_results();

        sender_idle_pct = 30;
        recv_stall_pct = 79;
        configure(4'b1111, 7'd125, 7'd0);
        random_traffic(ITEMS_PER_SECTION);
        drain_results();
        configure(4'($urandom_range(15)), 7'd0, 7'd127);
        random_traffic(ITEMS_PER_SECTION);
        drain_results();

        sender_idle_pct = 79;
        recv_stall_pct = 30;
        configure(4'b1111, 7'd2, 7'd127);
        random_traffic(ITEMS_PER_SECTION);
        drain_results();
        configure(4'b1111, 7'($urandom_range(125)), 7'($urandom_range(127)));
        random_traffic(ITEMS_PER_SECTION);
        drain_results();

        sender_idle_pct = 0;
        recv_stall_pct = 0;
        configure(4'b1111, 7'd125, 7'd73);
        hold_req = 1'b1;
        random_traffic(ITEMS_PER_SECTION);
        drain_results();
        configure(4'($urandom_range(15)), 7'd5, 7'($urandom_range(127)));
        random_traffic(ITEMS_PER_SECTION);
        drain_results();

        if (board.errors == 0 && board.outstanding() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

`default_nettype wire

[radio_frame_state_controller_unit.f]
src/rfsc_pkg.sv
src/radio_frame_state_controller_unit.sv
bench/tb_radio_frame_state_controller_unit.sv
